// ----- rtl/odq_pkg.sv -----
`timescale 1ns / 1ps
package odq_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      CMD_PUSH_BACK  = 2'd0,
      CMD_PUSH_FRONT = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_REMOVE     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [31:0] value_out;
      logic [1:0]  status;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop;
      logic remove;
   } op_type;

endpackage

// ----- rtl/odq_cell.sv -----
`timescale 1ns / 1ps
module odq_cell (
   input  logic               clock,
   input  odq_pkg::op_type    op,
   input  logic               occupied,
   input  logic               tail,
   input  odq_pkg::value_type key,
   input  odq_pkg::value_type prev_value,
   input  odq_pkg::value_type next_value,
   input  logic               hit_prior,
   output logic               hit_through,
   output odq_pkg::value_type value
);
   import odq_pkg::*;

   value_type data_ff;
   value_type data_in;

   assign hit_through = hit_prior | (occupied & (data_ff == key));
   assign value       = data_ff;

   always_comb begin
      data_in = data_ff;
      if (op.push_back && tail) begin
         data_in = key;
      end else if (op.push_front) begin
         data_in = prev_value;
      end else if (op.pop || (op.remove && hit_through)) begin
         data_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ----- rtl/ordered_deque_with_remove_top.sv -----
`timescale 1ns / 1ps
// Ordered deque of tag values with remove-by-value.
// Input channel: a command transaction (req_data.cmd, req_data.value_in) is
// taken on a rising edge with start high and busy low. busy stays low, so a
// command may be issued in every cycle.
// Commands: push back, push front, pop front, remove the first entry equal to
// value_in while closing the gap.
// Result channel: one result per command, on rsp_data with rsp_strobe high for
// exactly one cycle, the cycle after the command is taken (one command per
// cycle). The receiver cannot stall; each result must be taken as it appears.
// The entries live in a row of cells; every cell compares its entry against
// the key in parallel, and all cells shift to or from their neighbors together.
// Status: ok, empty on pop, full on push (value dropped), not found on remove.
// value_out is zero unless status is ok. occupancy is the count afterwards.
// Reset (synchronous, active high) empties the deque and clears rsp_strobe;
// entry contents are not cleared and are never read before being written.
module ordered_deque_with_remove_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  odq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output odq_pkg::rsp_type rsp_data
);
   import odq_pkg::*;

   count_type  count_ff;
   count_type  count_in;
   logic       strobe_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;

   logic       accept;
   logic       full;
   logic       empty;
   logic       found;
   value_type  key;
   logic [63:0] key_wide;
   logic [63:0] head_wide;
   logic [63:0] key_out_wide;
   op_type     op;

   value_type  cell_value [DEPTH];
   logic       hit_chain  [DEPTH+1];

   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign full     = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty    = (count_ff == '0);
   assign key_wide = 64'(req_data.value_in);
   assign key      = key_wide[VALUE_WIDTH-1:0];
   assign found    = hit_chain[DEPTH];
   assign hit_chain[0] = 1'b0;

   assign head_wide    = 64'(cell_value[0]);
   assign key_out_wide = 64'(key);

   always_comb begin
      op = '0;
      if (accept) begin
         case (cmd_type'(req_data.cmd))
            CMD_PUSH_BACK:  op.push_back  = ~full;
            CMD_PUSH_FRONT: op.push_front = ~full;
            CMD_POP_FRONT:  op.pop        = ~empty;
            CMD_REMOVE:     op.remove     = found;
            default:        op            = '0;
         endcase
      end
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         odq_cell u_cell (
            .clock       (clock),
            .op          (op),
            .occupied    (count_ff > COUNT_WIDTH'(i)),
            .tail        (count_ff == COUNT_WIDTH'(i)),
            .key         (key),
            .prev_value  ((i == 0) ? key : cell_value[(i == 0) ? 0 : i-1]),
            .next_value  (cell_value[(i == DEPTH-1) ? i : i+1]),
            .hit_prior   (hit_chain[i]),
            .hit_through (hit_chain[i+1]),
            .value       (cell_value[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      if (op.push_back || op.push_front) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (op.pop || op.remove) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
      case (cmd_type'(req_data.cmd))
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            rsp_in.status    = full ? ST_FULL : ST_OK;
            rsp_in.value_out = full ? '0 : key_out_wide[31:0];
         end
         CMD_POP_FRONT: begin
            rsp_in.status    = empty ? ST_EMPTY : ST_OK;
            rsp_in.value_out = empty ? '0 : head_wide[31:0];
         end
         CMD_REMOVE: begin
            rsp_in.status    = found ? ST_OK : ST_NOT_FOUND;
            rsp_in.value_out = found ? key_out_wide[31:0] : '0;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      rsp_in.occupancy = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- sim/ordered_deque_with_remove_top_tb.sv -----
`timescale 1ns / 1ps
module ordered_deque_with_remove_top_tb;
   import odq_pkg::*;

   localparam int RANDOM_COMMANDS = 1850;
   localparam int WATCHDOG_LIMIT  = 1000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   typedef struct {
      rsp_type predicted;
      bit      typed;
      rsp_type typed_rsp;
   } expect_type;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   bit      row_typed  = 1'b0;
   rsp_type row_rsp    = '0;

   value_type    deque_model[$];
   expect_type   pending_rsp[$];
   stim_row_type directed[$];

   int error_count   = 0;
   int checked_count = 0;
   int idle_cycles   = 0;
   int peak_occ      = 0;
   int status_seen[4];
   bit quiet_stretch = 1'b0;

   ordered_deque_with_remove_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, field, got, want);
      error_count++;
   endtask

   function automatic rsp_type predict_deque(req_type r);
      rsp_type res;
      int      hit;
      res = '0;
      case (cmd_type'(r.cmd))
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (deque_model.size() >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (r.cmd == CMD_PUSH_BACK) deque_model.push_back(r.value_in);
               else deque_model.push_front(r.value_in);
               res.value_out = r.value_in;
               res.status    = ST_OK;
            end
         end
         CMD_POP_FRONT: begin
            if (deque_model.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.value_out = deque_model.pop_front();
               res.status    = ST_OK;
            end
         end
         default: begin
            hit = -1;
            for (int i = 0; i < deque_model.size(); i++) begin
               if (hit < 0 && deque_model[i] == r.value_in) hit = i;
            end
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               deque_model.delete(hit);
               res.value_out = r.value_in;
               res.status    = ST_OK;
            end
         end
      endcase
      res.occupancy = 5'(deque_model.size());
      return res;
   endfunction

   // check results, then predict the transaction taken at this edge
   always @(posedge clock) begin
      expect_type exp_item;
      expect_type new_item;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("result with no command pending", 64'(1'b1), 64'(1'b0));
            end else begin
               exp_item = pending_rsp.pop_front();
               checked_count++;
               status_seen[rsp_data.status]++;
               if (rsp_data.value_out != exp_item.predicted.value_out)
                  report_mismatch("value_out", 64'(rsp_data.value_out),
                                  64'(exp_item.predicted.value_out));
               if (rsp_data.status != exp_item.predicted.status)
                  report_mismatch("status", 64'(rsp_data.status),
                                  64'(exp_item.predicted.status));
               if (rsp_data.occupancy != exp_item.predicted.occupancy)
                  report_mismatch("occupancy", 64'(rsp_data.occupancy),
                                  64'(exp_item.predicted.occupancy));
               if (exp_item.typed && rsp_data != exp_item.typed_rsp)
                  report_mismatch("table row", 64'(rsp_data), 64'(exp_item.typed_rsp));
            end
         end
         if (start && !busy) begin
            new_item.predicted = predict_deque(req_data);
            new_item.typed     = row_typed;
            new_item.typed_rsp = row_rsp;
            pending_rsp.push_back(new_item);
            if (deque_model.size() > peak_occ) peak_occ = deque_model.size();
         end
         if (rsp_strobe || (start && !busy)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("ordered_deque_with_remove_top test failed");
            $finish;
         end
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_stretch || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_command(req_type r, bit typed, rsp_type t);
      int gap;
      start     <= 1'b1;
      req_data  <= r;
      row_typed <= typed;
      row_rsp   <= t;
      do @(posedge clock); while (busy);
      gap = gap_length();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void add_row(cmd_type c, value_type v, bit typed,
                                   value_type ev, status_type es, int occ);
      stim_row_type row;
      row.req.cmd       = c;
      row.req.value_in  = v;
      row.typed         = typed;
      row.rsp.value_out = ev;
      row.rsp.status    = es;
      row.rsp.occupancy = 5'(occ);
      directed.push_back(row);
   endfunction

   function automatic value_type pick_value(bit search);
      int r;
      r = $urandom_range(0, 99);
      if (search && deque_model.size() != 0 && r < 60)
         return deque_model[$urandom_range(0, deque_model.size() - 1)];
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 7);
      if (r < 50) return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      if (r < 60) return 32'h1 << $urandom_range(0, 31);
      return $urandom();
   endfunction

   initial begin
      req_type req;
      int      mode;
      int      r;
      add_row(CMD_POP_FRONT,  32'h0,         1'b1, 32'h0,         ST_EMPTY,     0);
      add_row(CMD_REMOVE,     32'h5,         1'b1, 32'h0,         ST_NOT_FOUND, 0);
      add_row(CMD_PUSH_BACK,  32'h0,         1'b1, 32'h0,         ST_OK,        1);
      add_row(CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_OK,        2);
      add_row(CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, ST_OK,        3);
      add_row(CMD_PUSH_BACK,  32'h1234_5678, 1'b1, 32'h1234_5678, ST_OK,        4);
      add_row(CMD_PUSH_FRONT, 32'h1234_5678, 1'b1, 32'h1234_5678, ST_OK,        5);
      add_row(CMD_REMOVE,     32'h1234_5678, 1'b1, 32'h1234_5678, ST_OK,        4);
      add_row(CMD_REMOVE,     32'hDEAD_BEEF, 1'b1, 32'h0,         ST_NOT_FOUND, 4);
      add_row(CMD_POP_FRONT,  32'h0,         1'b0, 32'h0,         ST_OK,        0);
      for (int i = 0; i < 13; i++) begin
         add_row((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, 32'h1 << (i * 2 + 1),
                 1'b0, 32'h0, ST_OK, 0);
      end
      add_row(CMD_PUSH_BACK,  32'h0BAD_CAFE, 1'b1, 32'h0,         ST_FULL,      16);
      add_row(CMD_PUSH_FRONT, 32'h5555_5555, 1'b1, 32'h0,         ST_FULL,      16);
      add_row(CMD_REMOVE,     32'hFFFF_FFFF, 1'b0, 32'h0,         ST_OK,        0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_command(directed[i].req, directed[i].typed, directed[i].rsp);

      // fill-biased, drain-biased and balanced stretches
      mode = 0;
      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         if (n % 64 == 0) begin
            mode          = $urandom_range(0, 2);
            quiet_stretch = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         if ((mode == 0 && r < 75) || (mode == 1 && r < 25) || (mode == 2 && r < 50)) begin
            req.cmd = ($urandom_range(0, 1) == 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            req.value_in = pick_value(1'b0);
         end else if ($urandom_range(0, 1) == 0) begin
            req.cmd      = CMD_POP_FRONT;
            req.value_in = $urandom();
         end else begin
            req.cmd      = CMD_REMOVE;
            req.value_in = pick_value(1'b1);
         end
         send_command(req, 1'b0, '0);
      end
      start <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("%0d commands (%0d from the table) checked, peak occupancy %0d",
               checked_count, directed.size(), peak_occ);
      $display("statuses seen: ok %0d, empty %0d, full %0d, not found %0d",
               status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
               status_seen[ST_NOT_FOUND]);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("ordered_deque_with_remove_top test passed");
      end else begin
         $display("ordered_deque_with_remove_top test failed");
      end
      $finish;
   end

endmodule
